// ===== rtl/core/assert_macros.svh =====
// Assertion macros shared by the mixer RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, reset masked.
`define CDM_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, reset masked.
`define CDM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/cdm_pkg.sv =====
// Package for the curvature drive mixer: types, constants, remap table math.
`default_nettype none

package cdm_pkg;

    localparam int unsigned REMAP_INDEX_BITS_DEF = 10;

    // configuration port
    localparam int unsigned CFG_IDX_W  = 4;
    localparam int unsigned CFG_DATA_W = 15;

    localparam logic [CFG_IDX_W-1:0] CFG_DEADBAND     = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SLEW_STEP    = 4'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_INERTIA_GAIN = 4'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SENSITIVITY  = 4'd3;

    localparam logic [14:0] DEADBAND_RST     = 15'd1638;
    localparam logic [14:0] SLEW_STEP_RST    = 15'd328;
    localparam logic [11:0] INERTIA_GAIN_RST = 12'd1024;
    localparam logic [14:0] SENSITIVITY_RST  = 15'd16384;

    // shared multiplier operand width
    localparam int unsigned MUL_W = 20;

    typedef struct packed {
        logic [14:0] deadband;
        logic [14:0] slew_step;
        logic [11:0] inertia_gain;
        logic [14:0] sensitivity;
    } cdm_cfg_t;

    typedef struct packed {
        logic signed [15:0] left_drive;
        logic signed [15:0] right_drive;
        logic               turning_in_place;
    } cdm_result_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LOOK,
        ST_ACC,
        ST_SQ,
        ST_A,
        ST_LO,
        ST_HI,
        ST_MIX,
        ST_OUT
    } cdm_state_t;

    // Q30 constants for the double-sine remap curve (elaboration only)
    localparam longint unsigned Q30_ONE     = 64'd1 << 30;
    localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
    localparam longint unsigned ANGLE_Q30   = (HALF_PI_Q30 * 64'd13) / 64'd20;

    // sine by 9th-order Taylor series, Q30 in and out, divisions truncate
    function automatic longint unsigned sine_q30(longint unsigned x);
        longint unsigned x2;
        longint unsigned t;
        x2 = (x * x) >> 30;
        t  = Q30_ONE - x2 / 64'd72;
        t  = Q30_ONE - ((x2 * t) >> 30) / 64'd42;
        t  = Q30_ONE - ((x2 * t) >> 30) / 64'd20;
        t  = Q30_ONE - ((x2 * t) >> 30) / 64'd6;
        return (x * t) >> 30;
    endfunction

    localparam longint unsigned SIN_DEN = sine_q30(ANGLE_Q30);

    // remap table entry idx for a table of 2^bits + 1 entries, Q1.14
    function automatic logic [14:0] remap_entry(int unsigned idx, int unsigned bits);
        longint unsigned u;
        longint unsigned g;
        longint unsigned f;
        u = 64'(idx) << (30 - bits);
        g = (sine_q30((ANGLE_Q30 * u) >> 30) << 30) / SIN_DEN;
        f = (sine_q30((ANGLE_Q30 * g) >> 30) << 30) / SIN_DEN;
        return 15'((f + (64'd1 << 15)) >> 16);
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/curvature_drive_mixer_unit.sv =====
// Top level of the curvature drive mixer: ports, config registers, output register.
`default_nettype none
`include "assert_macros.svh"

// Curvature ("cheesy") drive mixer. Each request on the slave stream carries a
// Q1.14 throttle and turn; each produces exactly one result request on the
// master stream with Q1.14 left/right drive (saturated to 16 bits) and a flag
// in tuser that marks the point-turn path. The block keeps the previous
// throttle, previous turn and a negative-inertia accumulator between items.
// Timing: one item at a time. The engine steps through LOOK, ACC, SQ, A, LO,
// HI, MIX and OUT on the curvature path and through LOOK, ACC, SQ and OUT on
// the point-turn path; the result shows on m_tvalid as it leaves OUT, and
// s_tready returns in that same cycle. The steps are set by the single 20x20
// multiplier, which the sequencer reuses for the inertia step, the remap
// square and three steps of the curvature product. A result waiting on
// m_tready holds the engine in its last step; a new request is taken as soon
// as the engine is back in idle even while the previous result still waits.
// Remap table: 2^REMAP_INDEX_BITS + 1 constant entries, one registered read
// per item, issued on the accept edge. Config writes take effect at once and
// are meant to happen only while the block is idle; indexes above 3 are
// ignored and data is cut to each register's width.

module curvature_drive_mixer_unit #(
    parameter int unsigned REMAP_INDEX_BITS = cdm_pkg::REMAP_INDEX_BITS_DEF
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    // input stream
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    input  wire logic [31:0]                       s_tdata,   // [15:0] throttle, [31:16] turn
    // output stream
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    output logic [31:0]                            m_tdata,   // [15:0] left_drive, [31:16] right_drive
    output logic [0:0]                             m_tuser,   // [0] turning_in_place
    // configuration write port
    input  wire logic                              cfg_we,
    input  wire logic [cdm_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [cdm_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

    // ---------------------------------------------------------------
    // Configuration registers
    // ---------------------------------------------------------------
    cdm_pkg::cdm_cfg_t cfg_reg, cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                cdm_pkg::CFG_DEADBAND:     cfg_next.deadband     = cfg_wdata;
                cdm_pkg::CFG_SLEW_STEP:    cfg_next.slew_step    = cfg_wdata;
                cdm_pkg::CFG_INERTIA_GAIN: cfg_next.inertia_gain = cfg_wdata[11:0];
                cdm_pkg::CFG_SENSITIVITY:  cfg_next.sensitivity  = cfg_wdata;
                default:                   cfg_next = cfg_reg;  // unmapped index
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.deadband     <= cdm_pkg::DEADBAND_RST;
            cfg_reg.slew_step    <= cdm_pkg::SLEW_STEP_RST;
            cfg_reg.inertia_gain <= cdm_pkg::INERTIA_GAIN_RST;
            cfg_reg.sensitivity  <= cdm_pkg::SENSITIVITY_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // ---------------------------------------------------------------
    // Engine: sequencer around the shared multiplier
    // ---------------------------------------------------------------
    logic                   eng_idle;
    logic                   eng_done;
    logic                   out_free;
    cdm_pkg::cdm_result_t   eng_result;
    logic                   in_fire;

    assign s_tready = eng_idle;
    assign in_fire  = s_tvalid && s_tready;

    // output slot is free if empty or being drained this cycle
    assign out_free = !m_tvalid || m_tready;

    cdm_engine #(
        .INDEX_BITS (REMAP_INDEX_BITS)
    ) u_engine (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (in_fire),
        .throttle (s_tdata[15:0]),
        .turn     (s_tdata[31:16]),
        .cfg      (cfg_reg),
        .out_free (out_free),
        .idle     (eng_idle),
        .done     (eng_done),
        .result   (eng_result)
    );

    // ---------------------------------------------------------------
    // Output register: splits the engine from the downstream ready
    // ---------------------------------------------------------------
    logic                   out_valid_reg, out_valid_next;
    cdm_pkg::cdm_result_t   out_data_reg;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (eng_done)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (eng_done)
        begin
            out_data_reg <= eng_result;
        end
    end

    assign m_tvalid   = out_valid_reg;
    assign m_tdata    = {out_data_reg.right_drive, out_data_reg.left_drive};
    assign m_tuser[0] = out_data_reg.turning_in_place;

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    // one item in flight: ready drops right after a request is taken
    `CDM_ASSERT_NEXT(a_busy_after_accept, in_fire, !s_tready, "ready high after accept")
    // a fresh result appears exactly as the engine returns to idle
    `CDM_ASSERT_NOW(a_result_with_idle, $rose(m_tvalid), s_tready, "result without idle engine")
    // point turn drives the sides in exact opposition
    `CDM_ASSERT_NOW(a_point_turn_mirror, m_tvalid && m_tuser[0],
        (m_tdata[31:16] + m_tdata[15:0]) == 16'd0, "point turn sides not mirrored")

endmodule

`default_nettype wire

// ===== rtl/core/cdm_remap_rom.sv =====
// Double-sine turn remap table with registered read.
`default_nettype none

module cdm_remap_rom #(
    parameter int unsigned INDEX_BITS = cdm_pkg::REMAP_INDEX_BITS_DEF
) (
    input  wire logic                  clk,
    input  wire logic                  rd_en,
    input  wire logic [INDEX_BITS:0]   rd_idx,
    output logic      [14:0]           rd_data
);

    localparam int unsigned ROM_LEN = (1 << INDEX_BITS) + 1;

    logic [14:0] rom_tab [ROM_LEN];
    logic [14:0] rd_data_reg;

    for (genvar g = 0; g < ROM_LEN; g++)
    begin : g_rom
        assign rom_tab[g] = cdm_pkg::remap_entry(g, INDEX_BITS);
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= rom_tab[rd_idx];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// ===== rtl/core/cdm_mult.sv =====
// Shared unsigned multiplier with registered product.
`default_nettype none

module cdm_mult (
    input  wire logic                          clk,
    input  wire logic [cdm_pkg::MUL_W-1:0]     a,
    input  wire logic [cdm_pkg::MUL_W-1:0]     b,
    output logic      [2*cdm_pkg::MUL_W-1:0]   prod
);

    logic [2*cdm_pkg::MUL_W-1:0] prod_reg;

    always_ff @(posedge clk)
    begin
        prod_reg <= a * b;
    end

    assign prod = prod_reg;

endmodule

`default_nettype wire

// ===== rtl/core/cdm_engine.sv =====
// Sequencer and datapath: remap, slew, inertia, curvature mix on one multiplier.
`default_nettype none

module cdm_engine #(
    parameter int unsigned INDEX_BITS = cdm_pkg::REMAP_INDEX_BITS_DEF
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  start,
    input  wire logic signed [15:0]    throttle,
    input  wire logic signed [15:0]    turn,
    input  wire cdm_pkg::cdm_cfg_t     cfg,
    input  wire logic                  out_free,
    output logic                       idle,
    output logic                       done,
    output cdm_pkg::cdm_result_t       result
);

    localparam int unsigned IDX_W = INDEX_BITS + 1;
    localparam int unsigned MW    = cdm_pkg::MUL_W;

    localparam logic signed [21:0] ACC_HI = 22'sd524287;
    localparam logic signed [21:0] ACC_LO = -22'sd524288;
    localparam logic signed [19:0] ONE_Q14 = 20'sd16384;

    cdm_pkg::cdm_state_t state_reg, state_next;

    logic signed [15:0] thr_reg, thr_next;
    logic signed [15:0] trn_reg, trn_next;
    logic signed [15:0] last_thr_reg, last_thr_next;
    logic signed [15:0] last_trn_reg, last_trn_next;
    logic signed [19:0] acc_reg, acc_next;          // stored inertia accumulator
    logic signed [19:0] new_acc_reg, new_acc_next;  // this item's clamped accumulator
    logic signed [15:0] lin_reg, lin_next;
    logic               inplace_reg, inplace_next;
    logic               sum_neg_reg, sum_neg_next;
    logic [19:0]        sum_mag_reg, sum_mag_next;
    logic [14:0]        ahi_reg, ahi_next;
    logic [34:0]        lo_reg, lo_next;
    logic signed [24:0] ang_reg, ang_next;

    // ROM lookup address straight from the incoming turn
    logic [16:0]        trn_in_neg;
    logic [15:0]        trn_in_abs;
    logic [14:0]        trn_in_sat;
    logic [IDX_W-1:0]   rom_idx;
    logic [14:0]        rom_q;

    logic [MW-1:0]      mul_a, mul_b;
    logic [2*MW-1:0]    prod;

    assign trn_in_neg = -{turn[15], turn};
    assign trn_in_abs = turn[15] ? trn_in_neg[15:0] : turn;
    assign trn_in_sat = (trn_in_abs > 16'd16384) ? 15'd16384 : trn_in_abs[14:0];
    assign rom_idx    = trn_in_sat[14 -: IDX_W];

    cdm_remap_rom #(
        .INDEX_BITS (INDEX_BITS)
    ) u_rom (
        .clk     (clk),
        .rd_en   (start),
        .rd_idx  (rom_idx),
        .rd_data (rom_q)
    );

    cdm_mult u_mult (
        .clk  (clk),
        .a    (mul_a),
        .b    (mul_b),
        .prod (prod)
    );

    function automatic logic signed [15:0] sat16(logic signed [25:0] v);
        if (v > 26'sd32767)
        begin
            return 16'sh7FFF;
        end
        else if (v < -26'sd32768)
        begin
            return 16'sh8000;
        end
        return v[15:0];
    endfunction

    // combinational helpers from held registers
    logic signed [16:0] dturn;
    logic [16:0]        dturn_neg;
    logic [15:0]        dt_abs;
    logic [16:0]        thr_neg, trn_neg;
    logic [15:0]        thr_abs, trn_abs;
    logic signed [17:0] diff18, last18, s18, s2_18;
    logic [16:0]        lin_neg;
    logic [15:0]        lin_abs;
    logic [28:0]        acc_rnd_tmp;
    logic [20:0]        acc_rnd;
    logic signed [21:0] dt22, acc_sum;
    logic [29:0]        sq_tmp;
    logic [14:0]        sq_mag;
    logic signed [20:0] r21, sum21;
    logic [20:0]        sum_neg_v;
    logic [49:0]        total, total_rnd;
    logic [21:0]        ang_mag;
    logic signed [25:0] lin26, left26, right26;

    assign dturn     = {trn_reg[15], trn_reg} - {last_trn_reg[15], last_trn_reg};
    assign dturn_neg = -dturn;
    assign dt_abs    = dturn[16] ? dturn_neg[15:0] : dturn[15:0];
    assign thr_neg   = -{thr_reg[15], thr_reg};
    assign thr_abs   = thr_reg[15] ? thr_neg[15:0] : thr_reg;
    assign trn_neg   = -{trn_reg[15], trn_reg};
    assign trn_abs   = trn_reg[15] ? trn_neg[15:0] : trn_reg;

    assign diff18 = {{2{thr_reg[15]}}, thr_reg} - {{2{last_thr_reg[15]}}, last_thr_reg};
    assign last18 = {{2{last_thr_reg[15]}}, last_thr_reg};
    assign s18    = {3'b000, cfg.slew_step};
    assign s2_18  = {2'b00, cfg.slew_step, 1'b0};

    assign lin_neg = -{lin_reg[15], lin_reg};
    assign lin_abs = lin_reg[15] ? lin_neg[15:0] : lin_reg;

    // round half away from zero on magnitudes
    assign acc_rnd_tmp = {1'b0, prod[27:0]} + 29'd128;
    assign acc_rnd     = acc_rnd_tmp[28:8];
    assign dt22        = dturn[16] ? -$signed({1'b0, acc_rnd}) : $signed({1'b0, acc_rnd});
    assign acc_sum     = {{2{acc_reg[19]}}, acc_reg} + dt22;

    assign sq_tmp = {1'b0, prod[28:0]} + 30'd8192;
    assign sq_mag = sq_tmp[28:14];

    // r carries the turn's sign; a zero entry makes the sign moot
    assign r21       = trn_reg[15] ? -$signed({6'b0, rom_q}) : $signed({6'b0, rom_q});
    assign sum21     = r21 + {new_acc_reg[19], new_acc_reg};
    assign sum_neg_v = -sum21;

    assign total     = {prod[29:0], 20'b0} + {15'b0, lo_reg};
    assign total_rnd = total + 50'd134217728;
    assign ang_mag   = total_rnd[49:28];

    assign lin26   = {{10{lin_reg[15]}}, lin_reg};
    assign left26  = lin26 + {ang_reg[24], ang_reg};
    assign right26 = lin26 - {ang_reg[24], ang_reg};

    always_comb
    begin
        state_next    = state_reg;
        thr_next      = thr_reg;
        trn_next      = trn_reg;
        last_thr_next = last_thr_reg;
        last_trn_next = last_trn_reg;
        acc_next      = acc_reg;
        new_acc_next  = new_acc_reg;
        lin_next      = lin_reg;
        inplace_next  = inplace_reg;
        sum_neg_next  = sum_neg_reg;
        sum_mag_next  = sum_mag_reg;
        ahi_next      = ahi_reg;
        lo_next       = lo_reg;
        ang_next      = ang_reg;
        mul_a         = '0;
        mul_b         = '0;
        done          = 1'b0;
        idle          = 1'b0;
        result.left_drive       = sat16(left26);
        result.right_drive      = sat16(right26);
        result.turning_in_place = inplace_reg;

        case (state_reg)
            cdm_pkg::ST_IDLE:
            begin
                idle = 1'b1;
                if (start)
                begin
                    thr_next   = throttle;
                    trn_next   = turn;
                    state_next = cdm_pkg::ST_LOOK;
                end
            end
            cdm_pkg::ST_LOOK:
            begin
                inplace_next = (thr_abs < {1'b0, cfg.deadband}) &&
                               (trn_abs > {1'b0, cfg.deadband});
                if (diff18 > s18)
                begin
                    lin_next = 16'(last18 + s18);
                end
                else if (diff18 < -s2_18)
                begin
                    lin_next = 16'(last18 - s2_18);
                end
                else
                begin
                    lin_next = thr_reg;
                end
                mul_a      = {4'b0, dt_abs};
                mul_b      = {8'b0, cfg.inertia_gain};
                state_next = cdm_pkg::ST_ACC;
            end
            cdm_pkg::ST_ACC:
            begin
                if (acc_sum > ACC_HI)
                begin
                    new_acc_next = 20'sh7FFFF;
                end
                else if (acc_sum < ACC_LO)
                begin
                    new_acc_next = 20'sh80000;
                end
                else
                begin
                    new_acc_next = acc_sum[19:0];
                end
                mul_a      = {5'b0, rom_q};
                mul_b      = {5'b0, rom_q};
                state_next = cdm_pkg::ST_SQ;
            end
            cdm_pkg::ST_SQ:
            begin
                if (inplace_reg)
                begin
                    lin_next   = '0;
                    ang_next   = trn_reg[15] ? -$signed({10'b0, sq_mag})
                                             : $signed({10'b0, sq_mag});
                    state_next = cdm_pkg::ST_OUT;
                end
                else
                begin
                    sum_neg_next = sum21[20];
                    sum_mag_next = sum21[20] ? sum_neg_v[19:0] : sum21[19:0];
                    state_next   = cdm_pkg::ST_A;
                end
            end
            cdm_pkg::ST_A:
            begin
                mul_a      = {4'b0, lin_abs};
                mul_b      = sum_mag_reg;
                state_next = cdm_pkg::ST_LO;
            end
            cdm_pkg::ST_LO:
            begin
                ahi_next   = prod[34:20];
                mul_a      = prod[19:0];
                mul_b      = {5'b0, cfg.sensitivity};
                state_next = cdm_pkg::ST_HI;
            end
            cdm_pkg::ST_HI:
            begin
                lo_next    = prod[34:0];
                mul_a      = {5'b0, ahi_reg};
                mul_b      = {5'b0, cfg.sensitivity};
                state_next = cdm_pkg::ST_MIX;
            end
            cdm_pkg::ST_MIX:
            begin
                // |lin| is a magnitude, so only the remap + inertia sum sets the sign
                ang_next   = sum_neg_reg ? -$signed({3'b0, ang_mag})
                                         : $signed({3'b0, ang_mag});
                state_next = cdm_pkg::ST_OUT;
            end
            cdm_pkg::ST_OUT:
            begin
                if (out_free)
                begin
                    done          = 1'b1;
                    last_thr_next = thr_reg;
                    last_trn_next = trn_reg;
                    if (!inplace_reg)
                    begin
                        if (new_acc_reg > ONE_Q14)
                        begin
                            acc_next = new_acc_reg - ONE_Q14;
                        end
                        else if (new_acc_reg < -ONE_Q14)
                        begin
                            acc_next = new_acc_reg + ONE_Q14;
                        end
                        else
                        begin
                            acc_next = '0;
                        end
                    end
                    state_next = cdm_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = cdm_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= cdm_pkg::ST_IDLE;
            last_thr_reg <= '0;
            last_trn_reg <= '0;
            acc_reg      <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            last_thr_reg <= last_thr_next;
            last_trn_reg <= last_trn_next;
            acc_reg      <= acc_next;
        end
    end

    always_ff @(posedge clk)
    begin
        thr_reg     <= thr_next;
        trn_reg     <= trn_next;
        new_acc_reg <= new_acc_next;
        lin_reg     <= lin_next;
        inplace_reg <= inplace_next;
        sum_neg_reg <= sum_neg_next;
        sum_mag_reg <= sum_mag_next;
        ahi_reg     <= ahi_next;
        lo_reg      <= lo_next;
        ang_reg     <= ang_next;
    end

endmodule

`default_nettype wire

// ===== tb/curvature_drive_mixer_unit_tb.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for the curvature drive mixer: directed table, then random phases.

module curvature_drive_mixer_unit_tb;

    // remap curve, own copy: Q30 double sine, table of 2^bits + 1 entries
    localparam int unsigned     LUT_BITS         = cdm_pkg::REMAP_INDEX_BITS_DEF;
    localparam int              LUT_LAST         = 1 << LUT_BITS;
    localparam longint unsigned ONE_Q30          = 64'd1 << 30;
    localparam longint unsigned QUARTER_TURN_Q30 = 64'd1686629713;               // pi/2
    localparam longint unsigned BEND_Q30         = (QUARTER_TURN_Q30 * 64'd13) / 64'd20;

    localparam int Q14_UNIT = 16384;
    localparam int ACC_HI   = 524287;
    localparam int ACC_LO   = -524288;

    localparam int PHASES       = 8;
    localparam int PHASE_ITEMS  = 80;
    localparam int HOLD_PHASE   = 4;
    localparam int HOLD_CYCLES  = 400;
    localparam int SETTLE       = 2;
    localparam int DRAIN_CYCLES = 20;       // idle wait before the final missing-result check
    localparam int CYCLE_LIMIT  = 400000;
    localparam int SHOW_MAX     = 10;

    localparam logic [cdm_pkg::CFG_IDX_W-1:0] CFG_UNUSED_LO = 4'd4;
    localparam logic [cdm_pkg::CFG_IDX_W-1:0] CFG_UNUSED_HI = 4'd15;

    typedef enum logic { ROW_ITEM, ROW_CFG } row_kind_t;

    // one directed row: an item (a = throttle, b = turn) or a register write
    // (a = index, b = value); a typed row carries its own expected result
    typedef struct {
        row_kind_t            kind;
        logic [15:0]          a;
        logic [15:0]          b;
        bit                   typed;
        cdm_pkg::cdm_result_t want;
    } stim_row_t;

    logic                           clk       = 1'b0;
    logic                           rst_n     = 1'b0;
    logic                           s_tvalid  = 1'b0;
    logic                           s_tready;
    logic [31:0]                    s_tdata   = '0;
    logic                           m_tvalid;
    logic                           m_tready  = 1'b0;
    logic [31:0]                    m_tdata;
    logic [0:0]                     m_tuser;
    logic                           cfg_we    = 1'b0;
    logic [cdm_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [cdm_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;

    // predictor copy of the registers and the carried state
    int deadband_r = int'(cdm_pkg::DEADBAND_RST);
    int slew_r     = int'(cdm_pkg::SLEW_STEP_RST);
    int gain_r     = int'(cdm_pkg::INERTIA_GAIN_RST);
    int sens_r     = int'(cdm_pkg::SENSITIVITY_RST);
    int prev_thr   = 0;
    int prev_turn  = 0;
    int inertia_q  = 0;

    int                   remap_lut [0:LUT_LAST];
    cdm_pkg::cdm_result_t drive_q [$];       // expected drive results, oldest first
    stim_row_t            dir_tab [$];
    int                   errors  = 0;
    int                   calm_tx = 0;       // items left in a no-gap stretch on the sender
    bit                   hold_req = 1'b0;   // asks the sink for one long hold-off

    always #5 clk = ~clk;

    curvature_drive_mixer_unit u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // 9th order Taylor sine, Q30, truncating divides
    function automatic longint unsigned taylor_sin(longint unsigned x);
        longint unsigned sq;
        longint unsigned p;
        sq = (x * x) >> 30;
        p  = ONE_Q30 - sq / 64'd72;
        p  = ONE_Q30 - ((sq * p) >> 30) / 64'd42;
        p  = ONE_Q30 - ((sq * p) >> 30) / 64'd20;
        p  = ONE_Q30 - ((sq * p) >> 30) / 64'd6;
        return (x * p) >> 30;
    endfunction

    task automatic build_lut();
        longint unsigned den;
        longint unsigned u;
        longint unsigned g;
        longint unsigned f;
        int              i;
        den = taylor_sin(BEND_Q30);
        for (i = 0; i <= LUT_LAST; i++)
        begin
            u = longint'(i) << (30 - LUT_BITS);
            g = (taylor_sin((BEND_Q30 * u) >> 30) << 30) / den;
            f = (taylor_sin((BEND_Q30 * g) >> 30) << 30) / den;
            remap_lut[i] = int'((f + (64'd1 << 15)) >> 16);
        end
    endtask

    // |turn| saturates to 1.0, index truncates, sign goes back on after lookup
    function automatic int turn_curve(int t);
        int m;
        int idx;
        m = (t < 0) ? -t : t;
        if (m > Q14_UNIT)
            m = Q14_UNIT;
        idx = m >> (14 - LUT_BITS);
        if (idx > LUT_LAST)
            idx = LUT_LAST;
        return (t < 0) ? -remap_lut[idx] : remap_lut[idx];
    endfunction

    // right shift, rounding half away from zero
    function automatic longint rnd_shift(longint v, int sh);
        longint m;
        m = (v < 0) ? -v : v;
        m = (m + (64'sd1 <<< (sh - 1))) >>> sh;
        return (v < 0) ? -m : m;
    endfunction

    function automatic longint clip(longint v, longint lo, longint hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    // one mixer step: returns the drive result and advances the carried state
    function automatic cdm_pkg::cdm_result_t mix_drive(logic [15:0] thr_raw,
                                                       logic [15:0] turn_raw);
        int                   thr;
        int                   trn;
        int                   athr;
        int                   atrn;
        int                   r;
        int                   lin;
        longint               mag;
        longint               acc;
        longint               alin;
        longint               ang;
        longint               left;
        longint               right;
        cdm_pkg::cdm_result_t res;
        thr  = int'($signed(thr_raw));
        trn  = int'($signed(turn_raw));
        athr = (thr < 0) ? -thr : thr;
        atrn = (trn < 0) ? -trn : trn;
        r    = turn_curve(trn);
        res.turning_in_place = 1'b0;

        if (athr < deadband_r && atrn > deadband_r)
        begin
            // point turn: +-r*|r|, accumulator untouched
            mag   = rnd_shift(longint'(r) * longint'(r), 14);
            left  = (r < 0) ? -mag : mag;
            right = -left;
            res.turning_in_place = 1'b1;
        end
        else
        begin
            // forward slew limit, reverse limit at twice the step
            lin = thr;
            if (thr - prev_thr > slew_r)
                lin = prev_thr + slew_r;
            else if (thr - prev_thr < -2 * slew_r)
                lin = prev_thr - 2 * slew_r;

            acc = longint'(inertia_q)
                + rnd_shift(longint'(trn - prev_turn) * longint'(gain_r), 8);
            acc = clip(acc, ACC_LO, ACC_HI);

            alin  = (lin < 0) ? -longint'(lin) : longint'(lin);
            ang   = rnd_shift(alin * (longint'(r) + acc) * longint'(sens_r), 28);
            left  = clip(longint'(lin) + ang, -32768, 32767);
            right = clip(longint'(lin) - ang, -32768, 32767);

            // decay toward zero; exactly +-1.0 lands on zero
            if (acc > Q14_UNIT)
                acc = acc - Q14_UNIT;
            else if (acc < -Q14_UNIT)
                acc = acc + Q14_UNIT;
            else
                acc = 0;
            inertia_q = int'(acc);
        end

        prev_thr  = thr;
        prev_turn = trn;
        res.left_drive  = 16'(left);
        res.right_drive = 16'(right);
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Driving helpers
    // ------------------------------------------------------------------

    task automatic flag_error(string what, cdm_pkg::cdm_result_t want,
                              cdm_pkg::cdm_result_t got);
        errors++;
        if (errors <= SHOW_MAX)
            $display("%s: want L=%0d R=%0d P=%0d got L=%0d R=%0d P=%0d", what,
                     want.left_drive, want.right_drive, want.turning_in_place,
                     got.left_drive, got.right_drive, got.turning_in_place);
    endtask

    // register write; cfg_we then stays low before return, so it never drops and rises in one step
    task automatic cfg_write(logic [cdm_pkg::CFG_IDX_W-1:0] idx,
                             logic [cdm_pkg::CFG_DATA_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            cdm_pkg::CFG_DEADBAND:     deadband_r = int'(val);
            cdm_pkg::CFG_SLEW_STEP:    slew_r     = int'(val);
            cdm_pkg::CFG_INERTIA_GAIN: gain_r     = int'(val[11:0]);
            cdm_pkg::CFG_SENSITIVITY:  sens_r     = int'(val);
            default:                   ;
        endcase
        @(posedge clk);
    endtask

    // stop offering and let every pending result come back
    task automatic quiesce();
        s_tvalid <= 1'b0;
        while (drive_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    // one input request; valid stays up across back-to-back requests
    task automatic send_item(logic [15:0] thr, logic [15:0] trn, int gap, bit typed,
                             cdm_pkg::cdm_result_t want);
        cdm_pkg::cdm_result_t calc;
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {trn, thr};
        do
            @(posedge clk);
        while (s_tready !== 1'b1);
        calc = mix_drive(thr, trn);
        drive_q.push_back(typed ? want : calc);
    endtask

    task automatic add_row(row_kind_t kind, logic [15:0] a, logic [15:0] b, bit typed,
                           logic [15:0] wl, logic [15:0] wr, logic wp);
        stim_row_t row;
        row.kind  = kind;
        row.a     = a;
        row.b     = b;
        row.typed = typed;
        row.want.left_drive       = wl;
        row.want.right_drive      = wr;
        row.want.turning_in_place = wp;
        dir_tab.push_back(row);
    endtask

    // sender gaps: mostly none or short, a few long, now and then a calm stretch
    function automatic int tx_gap();
        int k;
        if (calm_tx > 0)
        begin
            calm_tx--;
            return 0;
        end
        k = $urandom_range(0, 99);
        if (k < 4)
        begin
            calm_tx = $urandom_range(20, 60);
            return 0;
        end
        if (k < 45)
            return 0;
        if (k < 92)
            return $urandom_range(1, 4);
        return $urandom_range(10, 40);
    endfunction

    function automatic int extreme_val();
        case ($urandom_range(0, 6))
            0:       return 0;
            1:       return 16384;
            2:       return -16384;
            3:       return 32767;
            4:       return -32768;
            5:       return 1;
            default: return -1;
        endcase
    endfunction

    task automatic pick_item(output logic [15:0] thr, output logic [15:0] trn);
        int k;
        int a;
        int b;
        k = $urandom_range(0, 99);
        if (k < 40)
        begin
            // ordinary joystick range
            a = $urandom_range(0, 32768) - 16384;
            b = $urandom_range(0, 32768) - 16384;
        end
        else if (k < 55)
        begin
            // around the point-turn boundary
            a = $urandom_range(0, 1) ? deadband_r + $urandom_range(0, 4) - 2
                                     : $urandom_range(0, deadband_r);
            b = deadband_r + $urandom_range(0, 6) - 3;
            if ($urandom_range(0, 1))
                a = -a;
            if ($urandom_range(0, 1))
                b = -b;
        end
        else if (k < 75)
        begin
            // walk the throttle along the slew limits, turn drifts
            a = prev_thr + ($urandom_range(0, 1) ? slew_r : -2 * slew_r)
              + $urandom_range(0, 4) - 2;
            b = prev_turn + $urandom_range(0, 1200) - 600;
        end
        else if (k < 88)
        begin
            // any 16 bit pattern
            a = $urandom_range(0, 65535) - 32768;
            b = $urandom_range(0, 65535) - 32768;
        end
        else
        begin
            a = extreme_val();
            b = extreme_val();
        end
        a = int'(clip(a, -32768, 32767));
        b = int'(clip(b, -32768, 32767));
        thr = 16'(a);
        trn = 16'(b);
    endtask

    // register set per phase: reset values, all zeros, large values, all ones, then random ones
    task automatic set_phase(int p);
        logic [cdm_pkg::CFG_DATA_W-1:0] db;
        logic [cdm_pkg::CFG_DATA_W-1:0] sl;
        logic [cdm_pkg::CFG_DATA_W-1:0] gn;
        logic [cdm_pkg::CFG_DATA_W-1:0] sn;
        case (p)
            0:
            begin
                db = cdm_pkg::DEADBAND_RST;
                sl = cdm_pkg::SLEW_STEP_RST;
                gn = 15'(cdm_pkg::INERTIA_GAIN_RST);
                sn = cdm_pkg::SENSITIVITY_RST;
            end
            1:
            begin
                db = '0;
                sl = '0;
                gn = '0;
                sn = '0;
            end
            2:
            begin
                db = 15'd16384;
                sl = 15'd16384;
                gn = 15'd4095;
                sn = 15'd32767;
            end
            3:
            begin
                // all ones; gain keeps only its low 12 bits
                db = '1;
                sl = '1;
                gn = '1;
                sn = '1;
            end
            default:
            begin
                db = 15'($urandom_range(0, 4000));
                sl = 15'($urandom_range(0, 2000));
                gn = 15'($urandom_range(0, 4095));
                sn = 15'($urandom_range(0, 32767));
                if ($urandom_range(0, 3) == 0)
                begin
                    db = 15'($urandom);
                    gn = 15'($urandom);
                end
            end
        endcase
        quiesce();
        cfg_write(cdm_pkg::CFG_DEADBAND, db);
        cfg_write(cdm_pkg::CFG_SLEW_STEP, sl);
        cfg_write(cdm_pkg::CFG_INERTIA_GAIN, gn);
        cfg_write(cdm_pkg::CFG_SENSITIVITY, sn);
        // unused index, must change nothing
        cfg_write(CFG_UNUSED_LO + 4'($urandom_range(0, 11)), 15'($urandom));
    endtask

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------

    initial
    begin : stim
        int          p;
        int          n;
        logic [15:0] thr;
        logic [15:0] trn;
        stim_row_t   row;

        build_lut();

        // directed table
        add_row(ROW_ITEM, 16'sd0, 16'sd0, 1'b1, 16'sd0, 16'sd0, 1'b0);      // after reset
        add_row(ROW_ITEM, 16'sd8000, 16'sd4096, 1'b0, '0, '0, 1'b0);       // acc exactly +1.0
        add_row(ROW_ITEM, 16'sd8000, 16'sd0, 1'b0, '0, '0, 1'b0);          // acc exactly -1.0
        add_row(ROW_ITEM, 16'sd0, 16'sd16384, 1'b0, '0, '0, 1'b0);         // point turn right
        add_row(ROW_ITEM, 16'sd0, -16'sd16384, 1'b0, '0, '0, 1'b0);        // point turn left
        add_row(ROW_ITEM, 16'sd1637, 16'sd1639, 1'b0, '0, '0, 1'b0);       // just inside deadband
        add_row(ROW_ITEM, 16'sd1638, 16'sd4000, 1'b0, '0, '0, 1'b0);       // throttle on the edge
        add_row(ROW_ITEM, -16'sd1637, 16'sd1638, 1'b0, '0, '0, 1'b0);      // turn on the edge
        add_row(ROW_ITEM, 16'sd16384, 16'sd16384, 1'b0, '0, '0, 1'b0);     // forward slew
        add_row(ROW_ITEM, -16'sd16384, -16'sd16384, 1'b0, '0, '0, 1'b0);   // reverse slew
        add_row(ROW_ITEM, 16'sh7FFF, 16'sh7FFF, 1'b0, '0, '0, 1'b0);       // beyond +1.0
        add_row(ROW_ITEM, 16'sh8000, 16'sh8000, 1'b0, '0, '0, 1'b0);       // beyond -1.0
        add_row(ROW_CFG, 16'(cdm_pkg::CFG_INERTIA_GAIN), 16'h7FFF, 1'b0, '0, '0,
                1'b0);                                                     // masked to 12 bits
        add_row(ROW_ITEM, 16'sd20000, 16'sh7FFF, 1'b0, '0, '0, 1'b0);      // accumulator high
        add_row(ROW_ITEM, 16'sd20000, 16'sh8000, 1'b0, '0, '0, 1'b0);      // accumulator low
        add_row(ROW_CFG, 16'(CFG_UNUSED_LO), 16'h0000, 1'b0, '0, '0, 1'b0);
        add_row(ROW_CFG, 16'(CFG_UNUSED_HI), 16'h7FFF, 1'b0, '0, '0, 1'b0);
        add_row(ROW_CFG, 16'(cdm_pkg::CFG_SENSITIVITY), 16'h0000, 1'b0, '0, '0, 1'b0);
        add_row(ROW_CFG, 16'(cdm_pkg::CFG_SLEW_STEP), 16'h7FFF, 1'b0, '0, '0, 1'b0);
        // no curvature, no slew: both sides follow the throttle
        add_row(ROW_ITEM, 16'sd12345, 16'sd5000, 1'b1, 16'sd12345, 16'sd12345, 1'b0);
        add_row(ROW_ITEM, 16'sh8000, 16'sh8000, 1'b1, 16'sh8000, 16'sh8000, 1'b0);
        add_row(ROW_CFG, 16'(cdm_pkg::CFG_DEADBAND), 16'h0000, 1'b0, '0, '0, 1'b0);
        add_row(ROW_ITEM, 16'sd0, 16'sd16384, 1'b0, '0, '0, 1'b0);         // no point turn at db 0
        add_row(ROW_CFG, 16'(cdm_pkg::CFG_DEADBAND), 16'h7FFF, 1'b0, '0, '0, 1'b0);
        add_row(ROW_ITEM, 16'sd100, 16'sh7FFF, 1'b0, '0, '0, 1'b0);        // turn equals deadband

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_tab[i])
        begin
            row = dir_tab[i];
            if (row.kind == ROW_CFG)
            begin
                quiesce();
                cfg_write(row.a[cdm_pkg::CFG_IDX_W-1:0], row.b[cdm_pkg::CFG_DATA_W-1:0]);
            end
            else
                send_item(row.a, row.b, tx_gap(), row.typed, row.want);
        end

        // random phases, registers rewritten while idle between them
        for (p = 0; p < PHASES; p++)
        begin
            set_phase(p);
            for (n = 0; n < PHASE_ITEMS; n++)
            begin
                // long sink hold-off while requests keep coming
                if (p == HOLD_PHASE && n == 10)
                    hold_req = 1'b1;
                pick_item(thr, trn);
                send_item(thr, trn, tx_gap(), 1'b0, '0);
            end
        end

        quiesce();
        repeat (DRAIN_CYCLES) @(posedge clk);
        foreach (drive_q[i])
            flag_error("missing result", drive_q[i], '0);

        if (errors == 0)
            $display("[curvature_drive_mixer_unit] OK");
        else
            $display("[curvature_drive_mixer_unit] ERROR");
        $finish;
    end

    // ------------------------------------------------------------------
    // Result sink: random m_tready, plus one long hold-off on request
    // ------------------------------------------------------------------

    initial
    begin : sink
        int k;
        int span;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (hold_req)
            begin
                hold_req = 1'b0;
                m_tready <= 1'b0;
                for (k = 0; k < HOLD_CYCLES; k++)
                    @(posedge clk);
            end
            else
            begin
                m_tready <= 1'b1;
                span = ($urandom_range(0, 19) == 0) ? $urandom_range(100, 200)
                                                    : $urandom_range(1, 10);
                repeat (span) @(posedge clk);
                k = $urandom_range(0, 99);
                span = (k < 35) ? 0 : ((k < 90) ? $urandom_range(1, 4)
                                                : $urandom_range(10, 50));
                if (span > 0)
                begin
                    m_tready <= 1'b0;
                    repeat (span) @(posedge clk);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Checker: each accepted result against the oldest expectation
    // ------------------------------------------------------------------

    always @(posedge clk)
    begin : check_drive
        cdm_pkg::cdm_result_t got;
        cdm_pkg::cdm_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got.left_drive       = m_tdata[15:0];
            got.right_drive      = m_tdata[31:16];
            got.turning_in_place = m_tuser[0];
            if (drive_q.size() == 0)
                flag_error("unexpected result", '0, got);
            else
            begin
                want = drive_q.pop_front();
                if (got.left_drive !== want.left_drive
                    || got.right_drive !== want.right_drive
                    || got.turning_in_place !== want.turning_in_place)
                    flag_error("drive mismatch", want, got);
            end
        end
    end

    // run limit
    initial
    begin : watchdog
        int cyc;
        cyc = 0;
        while (cyc < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cyc++;
        end
        $display("[curvature_drive_mixer_unit] ERROR");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+rtl/core
rtl/core/cdm_pkg.sv
rtl/core/cdm_remap_rom.sv
rtl/core/cdm_mult.sv
rtl/core/cdm_engine.sv
rtl/core/curvature_drive_mixer_unit.sv
tb/curvature_drive_mixer_unit_tb.sv
